@@ hw/rtl/bezier_curve_eval_defines.svh @@
// ----------------------------------------------------------------------------
// Bezier curve evaluator - assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef BEZIER_CURVE_EVAL_DEFINES_SVH
`define BEZIER_CURVE_EVAL_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define BCE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define BCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/bce_pkg.sv @@
// ----------------------------------------------------------------------------
// Bezier curve evaluator - package
// Field widths, codes and the three-lane point type.
// ----------------------------------------------------------------------------
package bce_pkg;

    localparam int LANES   = 3;          // x, y, z
    localparam int COORD_W = 32;         // Q16.16 coordinate
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PARAM_W = 18;         // Q2.16 curve parameter
    localparam int IDX_W   = 4;
    localparam int CNT_W   = 5;
    localparam int DATA_W  = 32;
    localparam int PADDR_W = 3;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    // Register index, taken from the word-address bit of paddr
    localparam logic REG_POINT_COUNT = 1'b0;

    localparam logic [CNT_W-1:0] POINT_COUNT_RST = CNT_W'(4);

    // Lane 0 is x, lane 1 is y, lane 2 is z
    typedef logic [LANES-1:0][COORD_W-1:0] t_point;

endpackage

@@ hw/rtl/bce_ram.sv @@
// ----------------------------------------------------------------------------
// Bezier curve evaluator - generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bce_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/bce_lerp.sv @@
// ----------------------------------------------------------------------------
// Bezier curve evaluator - shared interpolation unit
// Three-lane a + ((b - a) * t >>> FRAC_BITS), three register stages.
// ----------------------------------------------------------------------------
module bce_lerp #(
    parameter int FRAC_BITS = 16,
    parameter int TW        = 17,
    parameter int TAG_W     = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic [TAG_W-1:0]     i_tag,
    input  bce_pkg::t_point      i_a,
    input  bce_pkg::t_point      i_b,
    input  logic [TW-1:0]        i_t,
    output logic                 o_vld,
    output logic [TAG_W-1:0]     o_tag,
    output bce_pkg::t_point      o_res,
    output logic                 o_busy
);

    import bce_pkg::*;

    localparam int PW = DIFF_W + TW + 1;

    logic                             r_v1, r_v2, r_v3;
    logic [TAG_W-1:0]                 r_g1, r_g2, r_g3;
    t_point                           r_a1, r_a2;
    logic signed [LANES-1:0][DIFF_W-1:0] r_d1;
    logic signed [LANES-1:0][PW-1:0]  r_p2;
    t_point                           r_res;

    logic signed [LANES-1:0][PW-1:0]  w_prod;
    logic signed [LANES-1:0][PW-1:0]  w_sum;
    logic signed [PW-1:0]             w_tx;
    logic signed [PW-1:0]             w_dx;

    always_comb begin
        w_tx   = PW'($signed({1'b0, i_t}));
        w_prod = '0;
        w_sum  = '0;
        w_dx   = '0;
        for (int k = 0; k < LANES; k++) begin
            w_dx      = PW'($signed(r_d1[k]));
            w_prod[k] = w_dx * w_tx;
            w_sum[k]  = PW'($signed(r_a2[k])) + ($signed(r_p2[k]) >>> FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_g1 <= i_tag;
        r_g2 <= r_g1;
        r_g3 <= r_g2;
        r_a1 <= i_a;
        r_a2 <= r_a1;
        for (int k = 0; k < LANES; k++) begin
            r_d1[k]  <= DIFF_W'($signed(i_b[k])) - DIFF_W'($signed(i_a[k]));
            r_p2[k]  <= w_prod[k];
            r_res[k] <= w_sum[k][COORD_W-1:0];
        end
    end

    assign o_vld  = r_v3;
    assign o_tag  = r_g3;
    assign o_res  = r_res;
    assign o_busy = r_v1 || r_v2 || r_v3;

endmodule

@@ hw/rtl/bezier_curve_eval.sv @@
// ----------------------------------------------------------------------------
// Bezier curve evaluator - top level
// De Casteljau evaluation of a 3-D curve over one shared lerp unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready): a load item (mode 0) writes one
//   control point into slot point_index and gives no result; an evaluate item
//   (mode 1) clamps param_t to 0..1 and returns one point on the output
//   channel (o_out_valid / i_out_ready).
//   point_count is set over the APB port; the user must write it only while
//   idle, as the block itself does not enforce this. An evaluate item reads
//   control and scratch RAM one entry a cycle and runs every level through
//   the three-stage lerp unit, which drains between levels. o_in_ready is
//   high only while the sequencer is idle, so the next item can be taken in
//   the same cycle as the result is raised.
//   The result sits in an output register; the next item is accepted while it
//   waits. A finished result that meets a still-full output register is held
//   until the receiver takes the earlier one.
//   Reset clears the sequencer, the output valid and sets point_count to 4;
//   control point RAM is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
`include "bezier_curve_eval_defines.svh"

module bezier_curve_eval #(
    parameter int MAX_POINTS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bce_pkg::PADDR_W-1:0]        paddr,
    input  logic [bce_pkg::DATA_W-1:0]         pwdata,
    output logic [bce_pkg::DATA_W-1:0]         prdata,
    output logic                               pready,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_mode,
    input  logic [bce_pkg::IDX_W-1:0]          i_point_index,
    input  logic signed [bce_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [bce_pkg::COORD_W-1:0] i_coord_y,
    input  logic signed [bce_pkg::COORD_W-1:0] i_coord_z,
    input  logic signed [bce_pkg::PARAM_W-1:0] i_param_t,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [bce_pkg::COORD_W-1:0] o_out_x,
    output logic signed [bce_pkg::COORD_W-1:0] o_out_y,
    output logic signed [bce_pkg::COORD_W-1:0] o_out_z
);

    import bce_pkg::*;

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int TAG_W = AW + 1;
    localparam int TW    = (FRAC_BITS + 1 > PARAM_W - 1) ? FRAC_BITS + 1 : PARAM_W - 1;
    localparam int ONE   = 1 << FRAC_BITS;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ISSUE = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_SRD   = 3'd3;
    localparam logic [2:0] ST_SWAIT = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [AW-1:0]    r_lvl, n_lvl;
    logic [AW-1:0]    r_rd, n_rd;
    logic             r_from_ctrl, n_from_ctrl;
    logic [TW-1:0]    r_t, n_t;
    logic             r_rv;
    logic [AW-1:0]    r_rv_addr;
    logic             r_out_valid, n_out_valid;
    logic [CNT_W-1:0] r_point_count;
    t_point           r_a;
    t_point           r_res;
    t_point           r_out;

    logic             w_accept, w_query, w_load, w_cfg_wr, w_out_free;
    logic             w_rd_en;
    logic [AW-1:0]    w_rd_addr;
    logic [AW-1:0]    w_lvl0;
    logic [TW-1:0]    w_t_clamp;
    logic signed [31:0] w_p;
    logic [31:0]      w_pc;
    t_point           w_ctrl_q, w_work_q, w_src, w_load_pt;
    logic             w_lerp_vld;
    logic [TAG_W-1:0] w_lerp_tag;
    logic             w_lo_vld, w_lerp_busy;
    logic [TAG_W-1:0] w_lo_tag;
    t_point           w_lo_res;

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready &&
                      (paddr[PADDR_W-1] == REG_POINT_COUNT);
    assign prdata   = (paddr[PADDR_W-1] == REG_POINT_COUNT) ?
                      DATA_W'(r_point_count) : '0;

    // ---------------- input decode ----------------
    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_query    = w_accept && (i_mode == MODE_EVAL);
    assign w_load     = w_accept && (i_mode == MODE_LOAD) &&
                        (32'(i_point_index) < 32'(MAX_POINTS));
    assign w_load_pt  = {i_coord_z, i_coord_y, i_coord_x};

    // Clamp the parameter to 0..one
    assign w_p = 32'(i_param_t);
    always_comb begin
        if (w_p < 0) begin
            w_t_clamp = '0;
        end else if (w_p > ONE) begin
            w_t_clamp = TW'(ONE);
        end else begin
            w_t_clamp = TW'(w_p);
        end
    end

    // Levels to run: clamped count less one
    assign w_pc = 32'(r_point_count);
    always_comb begin
        if (w_pc == 32'd0) begin
            w_lvl0 = '0;
        end else if (w_pc > 32'(MAX_POINTS)) begin
            w_lvl0 = AW'(MAX_POINTS - 1);
        end else begin
            w_lvl0 = AW'(w_pc - 32'd1);
        end
    end

    // ---------------- memories ----------------
    assign w_rd_en   = (r_state == ST_ISSUE) || (r_state == ST_SRD);
    assign w_rd_addr = (r_state == ST_ISSUE) ? r_rd : '0;

    bce_ram #(
        .WIDTH (LANES * COORD_W),
        .DEPTH (MAX_POINTS)
    ) u_ctrl_ram (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (AW'(i_point_index)),
        .i_wdata (w_load_pt),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_ctrl_q)
    );

    bce_ram #(
        .WIDTH (LANES * COORD_W),
        .DEPTH (MAX_POINTS)
    ) u_work_ram (
        .i_clk   (i_clk),
        .i_we    (w_lo_vld),
        .i_waddr (w_lo_tag[AW-1:0]),
        .i_wdata (w_lo_res),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_work_q)
    );

    // ---------------- lerp feed ----------------
    // First level reads control points, later levels the scratch values.
    // Each read gives b for this step and a for the next one.
    assign w_src      = r_from_ctrl ? w_ctrl_q : w_work_q;
    assign w_lerp_vld = r_rv && (r_rv_addr != '0);
    assign w_lerp_tag = {(r_lvl == AW'(1)), AW'(r_rv_addr - AW'(1))};

    bce_lerp #(
        .FRAC_BITS (FRAC_BITS),
        .TW        (TW),
        .TAG_W     (TAG_W)
    ) u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_lerp_vld),
        .i_tag   (w_lerp_tag),
        .i_a     (r_a),
        .i_b     (w_src),
        .i_t     (r_t),
        .o_vld   (w_lo_vld),
        .o_tag   (w_lo_tag),
        .o_res   (w_lo_res),
        .o_busy  (w_lerp_busy)
    );

    // ---------------- sequencer ----------------
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_lvl       = r_lvl;
        n_rd        = r_rd;
        n_from_ctrl = r_from_ctrl;
        n_t         = r_t;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            ST_IDLE: begin
                if (w_query) begin
                    n_t         = w_t_clamp;
                    n_from_ctrl = 1'b1;
                    n_rd        = '0;
                    n_lvl       = w_lvl0;
                    n_state     = (w_lvl0 == '0) ? ST_SRD : ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (r_rd == r_lvl) begin
                    n_rd    = '0;
                    n_state = ST_DRAIN;
                end else begin
                    n_rd = r_rd + AW'(1);
                end
            end
            ST_DRAIN: begin
                // Wait for the last write of this level before reading it back
                if (!r_rv && !w_lerp_busy) begin
                    if (r_lvl == AW'(1)) begin
                        n_state = ST_FIN;
                    end else begin
                        n_lvl       = r_lvl - AW'(1);
                        n_from_ctrl = 1'b0;
                        n_state     = ST_ISSUE;
                    end
                end
            end
            ST_SRD: begin
                n_state = ST_SWAIT;
            end
            ST_SWAIT: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_lvl         <= '0;
            r_rd          <= '0;
            r_from_ctrl   <= 1'b0;
            r_rv          <= 1'b0;
            r_out_valid   <= 1'b0;
            r_point_count <= POINT_COUNT_RST;
        end else begin
            r_state     <= n_state;
            r_lvl       <= n_lvl;
            r_rd        <= n_rd;
            r_from_ctrl <= n_from_ctrl;
            r_rv        <= (r_state == ST_ISSUE);
            r_out_valid <= n_out_valid;
            if (w_cfg_wr) begin
                r_point_count <= pwdata[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_t       <= n_t;
        r_rv_addr <= r_rd;
        if (r_rv) begin
            r_a <= w_src;
        end
        if (r_state == ST_SWAIT) begin
            r_res <= w_ctrl_q;
        end else if (w_lo_vld && w_lo_tag[AW]) begin
            r_res <= w_lo_res;
        end
        if ((r_state == ST_FIN) && w_out_free) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_x     = $signed(r_out[0]);
    assign o_out_y     = $signed(r_out[1]);
    assign o_out_z     = $signed(r_out[2]);

    // ---------------- checks ----------------
    `BCE_ASSERT_NOW(a_idle_quiet, i_clk, i_rst_n, (r_state == ST_IDLE), (!r_rv && !w_lerp_busy), "lerp pipeline active while idle")
    `BCE_ASSERT_NOW(a_rd_in_level, i_clk, i_rst_n, (r_state == ST_ISSUE), ((r_rd <= r_lvl) && (r_lvl != '0)), "read address beyond current level")
    `BCE_ASSERT_NOW(a_out_from_fin, i_clk, i_rst_n, $rose(r_out_valid), ($past(r_state) == ST_FIN), "result raised outside final state")
    `BCE_ASSERT_NEXT(a_last_to_fin, i_clk, i_rst_n, (w_lo_vld && w_lo_tag[AW]), ((r_state == ST_DRAIN) || (r_state == ST_FIN)), "final lerp result outside drain")

endmodule

@@ verif/bezier_curve_eval_test.sv @@
// ----------------------------------------------------------------------------
// Bezier curve evaluator - self-checking testbench
// Loads control points and evaluates curves at a range of point counts. Every
// returned point is compared lane by lane with a local de Casteljau
// calculation or with the value listed in its directed row. The run mixes
// bursty input, receiver stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module bezier_curve_eval_test;
    import bce_pkg::*;

    localparam int     MAX_PTS       = 16;
    localparam int     FRAC          = 16;
    localparam longint T_ONE         = longint'(1) << FRAC;
    localparam int     SETTLE_CYCLES = 250;
    localparam int     HOLD_AT       = 150;
    localparam int     HOLD_CYCLES   = 1500;
    localparam longint LIMIT_TIME    = 64'd16_000_000;
    localparam logic [PADDR_W-1:0] CNT_ADDR = PADDR_W'(4 * REG_POINT_COUNT);

    typedef struct packed {
        logic               mode;
        logic [IDX_W-1:0]   idx;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] cz;
        logic [PARAM_W-1:0] param;
        logic               typed;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
        logic [COORD_W-1:0] ez;
    } t_row;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [PADDR_W-1:0]          paddr = '0;
    logic [DATA_W-1:0]           pwdata = '0;
    logic [DATA_W-1:0]           prdata;
    logic                        pready;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_ready;
    logic                        i_mode = MODE_LOAD;
    logic [IDX_W-1:0]            i_point_index = '0;
    logic signed [COORD_W-1:0]   i_coord_x = '0;
    logic signed [COORD_W-1:0]   i_coord_y = '0;
    logic signed [COORD_W-1:0]   i_coord_z = '0;
    logic signed [PARAM_W-1:0]   i_param_t = '0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    logic signed [COORD_W-1:0]   o_out_x;
    logic signed [COORD_W-1:0]   o_out_y;
    logic signed [COORD_W-1:0]   o_out_z;

    // Local copy of the block's state
    logic [CNT_W-1:0]   pt_count_cfg;
    t_point             ctrl_pts [MAX_PTS];
    logic [MAX_PTS-1:0] slot_written;
    t_point             pending_points [$];

    int n_errors = 0;
    int n_loads = 0;
    int n_evals = 0;
    int n_checked = 0;
    int n_settings = 0;
    int results_seen = 0;
    int hold_left = 0;
    int rx_style = 0;
    int rx_tick = 0;
    int burst_left = 0;
    bit no_gaps = 1'b0;
    t_point got_pt;
    t_point exp_pt;

    int unsigned cfg_plan [12] = '{1, 16, 0, 31, 2, 3, 7, 17, 5, 9, 12, 4};

    // Directed rows at the reset point count of four
    t_row dir_rows [17] = '{
        '{MODE_LOAD, 4'd0,  32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 18'h00000,
          1'b0, 32'h0, 32'h0, 32'h0},
        '{MODE_LOAD, 4'd1,  32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 18'h1FFFF,
          1'b0, 32'h0, 32'h0, 32'h0},
        '{MODE_LOAD, 4'd2,  32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678, 18'h20000,
          1'b0, 32'h0, 32'h0, 32'h0},
        '{MODE_LOAD, 4'd3,  32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, 18'h3FFFF,
          1'b0, 32'h0, 32'h0, 32'h0},
        '{MODE_EVAL, 4'd0,  32'h0, 32'h0, 32'h0, 18'h00000,
          1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000},
        '{MODE_EVAL, 4'd0,  32'h0, 32'h0, 32'h0, 18'h20000,
          1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000},
        '{MODE_EVAL, 4'd0,  32'h0, 32'h0, 32'h0, 18'h3FFFF,
          1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000},
        '{MODE_EVAL, 4'd0,  32'h0, 32'h0, 32'h0, 18'h10000,
          1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000},
        '{MODE_EVAL, 4'd0,  32'h0, 32'h0, 32'h0, 18'h1FFFF,
          1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000},
        // index and coordinates of an evaluate item must be ignored
        '{MODE_EVAL, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 18'h10001,
          1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000},
        '{MODE_EVAL, 4'd0,  32'h0, 32'h0, 32'h0, 18'h08000,
          1'b0, 32'h0, 32'h0, 32'h0},
        '{MODE_EVAL, 4'd0,  32'h0, 32'h0, 32'h0, 18'h00001,
          1'b0, 32'h0, 32'h0, 32'h0},
        '{MODE_EVAL, 4'd0,  32'h0, 32'h0, 32'h0, 18'h0FFFF,
          1'b0, 32'h0, 32'h0, 32'h0},
        '{MODE_LOAD, 4'd15, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 18'h00000,
          1'b0, 32'h0, 32'h0, 32'h0},
        '{MODE_LOAD, 4'd3,  32'h1234_5678, 32'h8765_4321, 32'h0000_FFFF, 18'h1FFFF,
          1'b0, 32'h0, 32'h0, 32'h0},
        '{MODE_EVAL, 4'd0,  32'h0, 32'h0, 32'h0, 18'h0C000,
          1'b0, 32'h0, 32'h0, 32'h0},
        '{MODE_EVAL, 4'd0,  32'h0, 32'h0, 32'h0, 18'h10000,
          1'b1, 32'h1234_5678, 32'h8765_4321, 32'h0000_FFFF}
    };

    bezier_curve_eval #(
        .MAX_POINTS (MAX_PTS),
        .FRAC_BITS  (FRAC)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_point_index (i_point_index),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_coord_z     (i_coord_z),
        .i_param_t     (i_param_t),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_out_z       (o_out_z)
    );

    always #4 i_clk = ~i_clk;

    task automatic report_fault(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        n_errors++;
    endtask

    function automatic int effective_count();
        if (pt_count_cfg == 0) begin
            return 1;
        end
        if (pt_count_cfg > MAX_PTS) begin
            return MAX_PTS;
        end
        return int'(pt_count_cfg);
    endfunction

    // De Casteljau reduction over the points in use, floor-shifted lerps
    function automatic t_point eval_curve(input logic [PARAM_W-1:0] t_raw);
        longint wk [MAX_PTS][LANES];
        longint t;
        int     n;
        t_point res;
        t = longint'($signed(t_raw));
        if (t < 0) begin
            t = 0;
        end
        if (t > T_ONE) begin
            t = T_ONE;
        end
        n = effective_count();
        for (int i = 0; i < n; i++) begin
            for (int l = 0; l < LANES; l++) begin
                wk[i][l] = longint'($signed(ctrl_pts[i][l]));
            end
        end
        for (int lvl = n - 1; lvl >= 1; lvl--) begin
            for (int j = 0; j < lvl; j++) begin
                for (int l = 0; l < LANES; l++) begin
                    wk[j][l] = wk[j][l] + (((wk[j+1][l] - wk[j][l]) * t) >>> FRAC);
                end
            end
        end
        for (int l = 0; l < LANES; l++) begin
            res[l] = wk[0][l][COORD_W-1:0];
        end
        return res;
    endfunction

    function automatic int next_gap();
        if (no_gaps) begin
            return 0;
        end
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            return $urandom_range(1, 10);
        end
        burst_left--;
        return 0;
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'hFFFF_FFFF;
                    default: return 32'h0;
                endcase
            end
            1: return COORD_W'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [PARAM_W-1:0] rand_param();
        case ($urandom_range(0, 9))
            0, 1: return PARAM_W'($urandom);
            2: return $urandom_range(0, 1) ? PARAM_W'(T_ONE) : '0;
            default: return PARAM_W'($urandom_range(0, 32'h10000));
        endcase
    endfunction

    // Evaluate only once every slot in use has been loaded; else load the gap
    function automatic t_row random_row();
        t_row r;
        int   n;
        r.mode  = $urandom_range(0, 1) ? MODE_EVAL : MODE_LOAD;
        r.idx   = IDX_W'($urandom_range(0, MAX_PTS - 1));
        r.cx    = rand_coord();
        r.cy    = rand_coord();
        r.cz    = rand_coord();
        r.param = rand_param();
        r.typed = 1'b0;
        r.ex    = '0;
        r.ey    = '0;
        r.ez    = '0;
        n = effective_count();
        if (r.mode == MODE_EVAL) begin
            for (int i = n - 1; i >= 0; i--) begin
                if (!slot_written[i]) begin
                    r.mode = MODE_LOAD;
                    r.idx  = IDX_W'(i);
                end
            end
        end
        return r;
    endfunction

    task automatic send_item(input t_row r, input int gap);
        t_point p;
        i_in_valid    <= 1'b1;
        i_mode        <= r.mode;
        i_point_index <= r.idx;
        i_coord_x     <= r.cx;
        i_coord_y     <= r.cy;
        i_coord_z     <= r.cz;
        i_param_t     <= r.param;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        if (r.mode == MODE_LOAD) begin
            ctrl_pts[r.idx][0] = r.cx;
            ctrl_pts[r.idx][1] = r.cy;
            ctrl_pts[r.idx][2] = r.cz;
            slot_written[r.idx] = 1'b1;
            n_loads++;
        end else begin
            if (r.typed) begin
                p[0] = r.ex;
                p[1] = r.ey;
                p[2] = r.ez;
            end else begin
                p = eval_curve(r.param);
            end
            pending_points.push_back(p);
            n_evals++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        while (pending_points.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the point count, then read it back
    task automatic write_point_count(input logic [DATA_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CNT_ADDR;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        pt_count_cfg = val[CNT_W-1:0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        if (prdata[CNT_W-1:0] !== val[CNT_W-1:0]) begin
            report_fault($sformatf("point_count read back %0d, wrote %0d",
                                   prdata[CNT_W-1:0], val[CNT_W-1:0]));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        n_settings++;
    endtask

    // Receiver: check each accepted point, then choose the next ready level
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got_pt[0] = o_out_x;
            got_pt[1] = o_out_y;
            got_pt[2] = o_out_z;
            if (pending_points.size() == 0) begin
                report_fault($sformatf("point %h %h %h with none pending",
                                       o_out_x, o_out_y, o_out_z));
            end else begin
                exp_pt = pending_points.pop_front();
                n_checked++;
                for (int l = 0; l < LANES; l++) begin
                    if (got_pt[l] !== exp_pt[l]) begin
                        report_fault($sformatf("evaluation %0d lane %0d: got %h, want %h",
                                               n_checked, l, got_pt[l], exp_pt[l]));
                    end
                end
            end
            results_seen++;
            if (results_seen == HOLD_AT) begin
                hold_left = HOLD_CYCLES;
            end
        end
        rx_tick++;
        if (hold_left > 0) begin
            // long hold-off: the block fills and stops taking items
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            case (rx_style)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= 1'($urandom_range(0, 1));
                2: i_out_ready <= (rx_tick % 7) >= 3;
                default: i_out_ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    initial begin
        #(LIMIT_TIME);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int   n_items;
        t_row r;
        pt_count_cfg = POINT_COUNT_RST;
        slot_written = '0;
        for (int i = 0; i < MAX_PTS; i++) begin
            ctrl_pts[i] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rx_style = 1;
        foreach (dir_rows[k]) begin
            send_item(dir_rows[k], next_gap());
        end
        i_in_valid <= 1'b0;

        for (int ph = 0; ph < 12; ph++) begin
            wait_idle();
            write_point_count(DATA_W'(cfg_plan[ph]));
            rx_style = ph % 4;
            no_gaps  = (ph % 3) == 2;
            // keep the slow settings of twelve points or more short
            n_items  = (effective_count() >= 12) ? 60 : 200;
            for (int k = 0; k < n_items; k++) begin
                r = random_row();
                send_item(r, next_gap());
            end
            i_in_valid <= 1'b0;
        end

        wait_idle();
        if (pending_points.size() != 0) begin
            report_fault($sformatf("%0d points never returned", pending_points.size()));
        end
        $display("Sent %0d loads and %0d evaluations over %0d point-count settings.",
                 n_loads, n_evals, n_settings + 1);
        $display("Compared %0d evaluated points; %0d mismatches.", n_checked, n_errors);
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
